// ----- rtl/ybd_pkg.sv -----
// ----------------------------------------------------------------------------
// ybd_pkg
// Shared types, constants and constant tables of the region box decoder.
// ----------------------------------------------------------------------------
package ybd_pkg;

    localparam int GRID_MAX    = 64;
    localparam int CLASS_MAX   = 2;
    localparam int TABLE_DEPTH = 1024;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int SIG_W       = 16;
    localparam int EXP_W       = 26;

    // divider geometry: dividend, divisor, quotient and partial remainder
    localparam int DVD_W   = 46;
    localparam int DVS_W   = 24;
    localparam int QUO_W   = 16;
    localparam int REM_W   = DVS_W + QUO_W;
    localparam int DIV_LAT = QUO_W + 1;

    // divider lanes
    localparam int DIV_CX = 0;
    localparam int DIV_CY = 1;
    localparam int DIV_BW = 2;
    localparam int DIV_BH = 3;
    localparam int DIV_N  = 4;

    typedef enum logic [2:0] {
        REG_THRESHOLD = 3'd0,
        REG_MODEL_W   = 3'd1,
        REG_MODEL_H   = 3'd2,
        REG_IMAGE_W   = 3'd3,
        REG_IMAGE_H   = 3'd4,
        REG_CLASS_CNT = 3'd5
    } t_reg_idx;

    typedef logic [SIG_W-1:0] t_sig_rom [TABLE_DEPTH];
    typedef logic [EXP_W-1:0] t_exp_rom [TABLE_DEPTH];

    typedef struct packed {
        logic        [5:0]  cell_x;
        logic        [5:0]  cell_y;
        logic        [6:0]  grid_size;
        logic        [9:0]  anchor_w;
        logic        [9:0]  anchor_h;
        logic signed [15:0] logit_x;
        logic signed [15:0] logit_y;
        logic signed [15:0] logit_w;
        logic signed [15:0] logit_h;
        logic signed [15:0] logit_obj;
        logic signed [15:0] class_logit_a;
        logic signed [15:0] class_logit_b;
    } t_item;

    // configuration, with the products that only depend on it
    typedef struct packed {
        logic [15:0] thr;
        logic        two_cls;
        logic [11:0] m;
        logic [12:0] iw;
        logic [25:0] ax;
        logic [25:0] ay;
        logic [24:0] bx;
        logic [24:0] by;
        logic [24:0] ch;
        logic [23:0] mwm;
    } t_cfg;

    typedef struct packed {
        logic        pass;
        logic [15:0] score;
        logic        cls;
        logic        neg_x;
        logic        neg_y;
    } t_side;

    typedef struct packed {
        logic [DVD_W-1:0] dvd;
        logic [DVS_W-1:0] dvs;
    } t_div_req;

    // truncating signed division by shift and subtract, table build only
    function automatic longint f_sdiv(input longint n, input longint d);
        logic [63:0] un;
        logic [63:0] ud;
        logic [63:0] q;
        logic [64:0] r;
        un = (n < 0) ? 64'(-n) : 64'(n);
        ud = (d < 0) ? 64'(-d) : 64'(d);
        q  = '0;
        r  = '0;
        for (int b = 63; b >= 0; b--) begin
            r = {r[63:0], un[b]};
            if (r >= 65'(ud)) begin
                r    = r - 65'(ud);
                q[b] = 1'b1;
            end
        end
        return ((n < 0) != (d < 0)) ? -longint'(q) : longint'(q);
    endfunction

    // e^x, x in Q16.16 with |x| <= 8, result in Q24
    function automatic logic [63:0] f_exp_q24(input longint xq16);
        longint      one;
        longint      y;
        longint      term;
        longint      sum;
        logic [63:0] s;
        one  = longint'(1) <<< 30;
        y    = xq16 * 1024;
        term = one;
        sum  = one;
        for (int k = 1; k <= 12; k++) begin
            term = f_sdiv(term * y, longint'(k) * one);
            sum  = sum + term;
        end
        s = unsigned'(sum) >> 6;
        for (int k = 0; k < 4; k++) begin
            s = (s * s + 64'd8388608) >> 24;
        end
        return s;
    endfunction

    function automatic longint f_sample(input int i);
        return (longint'(2 * i + 1) * 524288) / TABLE_DEPTH - 524288;
    endfunction

    function automatic t_sig_rom f_build_sig();
        t_sig_rom    r;
        logic [63:0] en;
        logic [63:0] den;
        logic [63:0] sg;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            en   = f_exp_q24(-f_sample(i));
            den  = (64'd1 << 24) + en;
            sg   = f_sdiv(longint'((64'd1 << 40) + (den >> 1)), longint'(den));
            r[i] = (sg > 64'd65535) ? 16'hFFFF : sg[15:0];
        end
        return r;
    endfunction

    function automatic t_exp_rom f_build_exp();
        t_exp_rom    r;
        logic [63:0] ex;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            ex   = (f_exp_q24(f_sample(i)) + 64'd128) >> 8;
            r[i] = (ex > 64'h3FF_FFFF) ? {EXP_W{1'b1}} : ex[EXP_W-1:0];
        end
        return r;
    endfunction

    localparam t_sig_rom SIG_ROM = f_build_sig();
    localparam t_exp_rom EXP_ROM = f_build_exp();

    // clamp a Q8.8 logit to [-8, 8) and map it onto a table bin
    function automatic logic [IDX_W-1:0] f_tab_index(input logic signed [15:0] v);
        logic [11:0] u;
        logic [24:0] p;
        if (v < -16'sd2048) begin
            u = 12'h000;
        end else if (v > 16'sd2047) begin
            u = 12'hFFF;
        end else begin
            u = v[11:0] ^ 12'h800;
        end
        p = 25'(u) * 25'(TABLE_DEPTH);
        return p[12 +: IDX_W];
    endfunction

endpackage

// ----- rtl/ybd_div.sv -----
// ----------------------------------------------------------------------------
// ybd_div
// Pipelined restoring divider, one quotient bit per stage, with an
// overflow flag for quotients that do not fit.
// ----------------------------------------------------------------------------
module ybd_div (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic [ybd_pkg::DVD_W-1:0] i_dvd,
    input  logic [ybd_pkg::DVS_W-1:0] i_dvs,
    output logic [ybd_pkg::QUO_W-1:0] o_quot,
    output logic                      o_ovf
);
    import ybd_pkg::*;

    logic [REM_W-1:0] r_rem [DIV_LAT];
    logic [DVS_W-1:0] r_dvs [DIV_LAT];
    logic [QUO_W-1:0] r_q   [DIV_LAT];
    logic             r_ovf [DIV_LAT];

    logic [REM_W-1:0] n_shift [1:DIV_LAT-1];
    logic             n_take  [1:DIV_LAT-1];

    always_comb begin
        for (int s = 1; s < DIV_LAT; s++) begin
            n_shift[s] = REM_W'(r_dvs[s-1]) << (QUO_W - s);
            n_take[s]  = r_rem[s-1] >= n_shift[s];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // remainder is only meaningful when the quotient fits
            r_ovf[0] <= i_dvd >= DVD_W'({i_dvs, {QUO_W{1'b0}}});
            r_rem[0] <= i_dvd[REM_W-1:0];
            r_dvs[0] <= i_dvs;
            r_q[0]   <= '0;
            for (int s = 1; s < DIV_LAT; s++) begin
                r_rem[s] <= n_take[s] ? (r_rem[s-1] - n_shift[s]) : r_rem[s-1];
                r_q[s]   <= r_q[s-1] | (QUO_W'(n_take[s]) << (QUO_W - s));
                r_dvs[s] <= r_dvs[s-1];
                r_ovf[s] <= r_ovf[s-1];
            end
        end
    end

    assign o_quot = r_q[DIV_LAT-1];
    assign o_ovf  = r_ovf[DIV_LAT-1];

endmodule

// ----- rtl/ybd_front.sv -----
// ----------------------------------------------------------------------------
// ybd_front
// Table lookup, score, products and divider operands: four pipeline stages.
// ----------------------------------------------------------------------------
module ybd_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  ybd_pkg::t_item    i_item,
    input  ybd_pkg::t_cfg     i_cfg,
    output logic              o_valid,
    output ybd_pkg::t_side    o_side,
    output ybd_pkg::t_div_req o_div [ybd_pkg::DIV_N]
);
    import ybd_pkg::*;

    // stage 1: table reads
    logic             r_s1_v;
    logic [SIG_W-1:0] r_s1_sig_x, r_s1_sig_y, r_s1_sig_obj, r_s1_sig_a, r_s1_sig_b;
    logic [EXP_W-1:0] r_s1_exp_w, r_s1_exp_h;
    logic [5:0]       r_s1_cell_x, r_s1_cell_y;
    logic [6:0]       r_s1_g;
    logic [9:0]       r_s1_aw, r_s1_ah;
    logic [6:0]       n_g;

    // stage 2: products
    logic             r_s2_v;
    logic [31:0]      r_s2_prod;
    logic             r_s2_cls;
    logic [47:0]      r_s2_axcs, r_s2_aycs;
    logic [31:0]      r_s2_bxg, r_s2_byg;
    logic [18:0]      r_s2_gm;
    logic [EXP_W-1:0] r_s2_exp_w, r_s2_exp_h;
    logic [22:0]      r_s2_awiw;
    logic [34:0]      r_s2_ahch;
    logic [SIG_W-1:0] n_best;
    logic             n_cls;

    // stage 3: centre numerators, size products, score
    logic               r_s3_v;
    logic               r_s3_pass;
    logic [15:0]        r_s3_score;
    logic               r_s3_cls;
    logic signed [48:0] r_s3_num_x, r_s3_num_y;
    logic [18:0]        r_s3_gm;
    logic [48:0]        r_s3_pw;
    logic [43:0]        r_s3_ph_lo;
    logic [42:0]        r_s3_ph_hi;
    logic [15:0]        n_score;

    // stage 4: divider operands
    logic     r_s4_v;
    t_side    r_s4_side;
    t_div_req r_s4_div [DIV_N];
    logic [49:0] n_sum_x, n_sum_y, n_sum_w, n_t;
    logic [61:0] n_sum_h;

    always_comb begin
        n_g = i_item.grid_size;
        if (n_g == 7'd0) begin
            n_g = 7'd1;
        end else if (32'(n_g) > GRID_MAX) begin
            n_g = 7'(GRID_MAX);
        end
    end

    // first class wins a tie
    always_comb begin
        n_best = r_s1_sig_a;
        n_cls  = 1'b0;
        if (i_cfg.two_cls && (r_s1_sig_b > r_s1_sig_a)) begin
            n_best = r_s1_sig_b;
            n_cls  = 1'b1;
        end
    end

    assign n_score = 16'((r_s2_prod + 32'd32768) >> 16);

    // rounding offsets of half the divisor: added to the signed centre's magnitude and to the size products
    always_comb begin
        n_t     = 50'({r_s3_gm, 16'b0});
        n_sum_x = r_s3_num_x[48] ? (n_t - 50'(r_s3_num_x)) : (n_t + 50'(r_s3_num_x));
        n_sum_y = r_s3_num_y[48] ? (n_t - 50'(r_s3_num_y)) : (n_t + 50'(r_s3_num_y));
        n_sum_w = 50'(r_s3_pw) + 50'({i_cfg.m, 15'b0});
        n_sum_h = 62'({r_s3_ph_hi, 18'b0}) + 62'(r_s3_ph_lo) + 62'({i_cfg.mwm, 15'b0});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
            r_s4_v <= 1'b0;
        end else if (i_en) begin
            r_s1_v <= i_valid;
            r_s2_v <= r_s1_v;
            r_s3_v <= r_s2_v;
            r_s4_v <= r_s3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_sig_x   <= SIG_ROM[f_tab_index(i_item.logit_x)];
            r_s1_sig_y   <= SIG_ROM[f_tab_index(i_item.logit_y)];
            r_s1_sig_obj <= SIG_ROM[f_tab_index(i_item.logit_obj)];
            r_s1_sig_a   <= SIG_ROM[f_tab_index(i_item.class_logit_a)];
            r_s1_sig_b   <= SIG_ROM[f_tab_index(i_item.class_logit_b)];
            r_s1_exp_w   <= EXP_ROM[f_tab_index(i_item.logit_w)];
            r_s1_exp_h   <= EXP_ROM[f_tab_index(i_item.logit_h)];
            r_s1_cell_x  <= i_item.cell_x;
            r_s1_cell_y  <= i_item.cell_y;
            r_s1_g       <= n_g;
            r_s1_aw      <= i_item.anchor_w;
            r_s1_ah      <= i_item.anchor_h;

            r_s2_prod  <= 32'(n_best) * 32'(r_s1_sig_obj);
            r_s2_cls   <= n_cls;
            r_s2_axcs  <= 48'(i_cfg.ax) * 48'({r_s1_cell_x, r_s1_sig_x});
            r_s2_aycs  <= 48'(i_cfg.ay) * 48'({r_s1_cell_y, r_s1_sig_y});
            r_s2_bxg   <= 32'(i_cfg.bx) * 32'(r_s1_g);
            r_s2_byg   <= 32'(i_cfg.by) * 32'(r_s1_g);
            r_s2_gm    <= 19'(r_s1_g) * 19'(i_cfg.m);
            r_s2_exp_w <= r_s1_exp_w;
            r_s2_exp_h <= r_s1_exp_h;
            r_s2_awiw  <= 23'(r_s1_aw) * 23'(i_cfg.iw);
            r_s2_ahch  <= 35'(r_s1_ah) * 35'(i_cfg.ch);

            r_s3_score <= n_score;
            r_s3_pass  <= n_score > i_cfg.thr;
            r_s3_cls   <= r_s2_cls;
            r_s3_num_x <= $signed({1'b0, r_s2_axcs}) - $signed({1'b0, r_s2_bxg, 16'b0});
            r_s3_num_y <= $signed({1'b0, r_s2_aycs}) - $signed({1'b0, r_s2_byg, 16'b0});
            r_s3_gm    <= r_s2_gm;
            r_s3_pw    <= 49'(r_s2_exp_w) * 49'(r_s2_awiw);
            // height product split in two partial products
            r_s3_ph_lo <= 44'(r_s2_exp_h) * 44'(r_s2_ahch[17:0]);
            r_s3_ph_hi <= 43'(r_s2_exp_h) * 43'(r_s2_ahch[34:18]);

            r_s4_side.pass  <= r_s3_pass;
            r_s4_side.score <= r_s3_score;
            r_s4_side.cls   <= r_s3_cls;
            r_s4_side.neg_x <= r_s3_num_x[48];
            r_s4_side.neg_y <= r_s3_num_y[48];
            r_s4_div[DIV_CX].dvd <= DVD_W'(n_sum_x >> 17);
            r_s4_div[DIV_CX].dvs <= DVS_W'(r_s3_gm);
            r_s4_div[DIV_CY].dvd <= DVD_W'(n_sum_y >> 17);
            r_s4_div[DIV_CY].dvs <= DVS_W'(r_s3_gm);
            r_s4_div[DIV_BW].dvd <= DVD_W'(n_sum_w >> 16);
            r_s4_div[DIV_BW].dvs <= DVS_W'(i_cfg.m);
            r_s4_div[DIV_BH].dvd <= DVD_W'(n_sum_h >> 16);
            r_s4_div[DIV_BH].dvs <= i_cfg.mwm;
        end
    end

    assign o_valid = r_s4_v;
    assign o_side  = r_s4_side;
    assign o_div   = r_s4_div;

endmodule

// ----- rtl/yolo_box_decode.sv -----
// ----------------------------------------------------------------------------
// yolo_box_decode
// Region box decoder: one grid cell and anchor in, at most one detection out.
// A request passes the front stages, the divider stages and the output register before o_m_tvalid.
// Throughput: one request per cycle while the output is not stalled; the 17 stage divider sets the depth.
// A stall at the output holds the whole pipeline in place.
// Reset (synchronous) clears all valid bits and loads the register defaults;
// the lookup tables are constant, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module yolo_box_decode (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // cell_x, cell_y, grid_size, anchor_w, anchor_h, logit_x, logit_y,
    // logit_w, logit_h, logit_obj, class_logit_a, class_logit_b
    input  logic [151:0] i_s_tdata,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // box_cx, box_cy, box_width, box_height, score
    output logic [79:0]  o_m_tdata,
    // best class index
    output logic [0:0]   o_m_tuser,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import ybd_pkg::*;

    logic [15:0] r_thr;
    logic [11:0] r_mw, r_mh;
    logic [12:0] r_iw, r_ih;
    logic [1:0]  r_cls_cnt;
    t_cfg        r_cfg;
    logic [11:0] n_mw, n_mh, n_m;

    logic        en;
    t_item       item;
    logic        f_valid;
    t_side       f_side;
    t_div_req    f_div [DIV_N];
    logic [QUO_W-1:0] quot [DIV_N];
    logic             ovf  [DIV_N];

    logic        r_sb_v [DIV_LAT];
    t_side       r_sb   [DIV_LAT];

    logic        r_out_v;
    logic [13:0] r_cx, r_cy;
    logic [15:0] r_bw, r_bh, r_score;
    logic        r_cls;
    logic [13:0] n_cx, n_cy;
    t_side       sb;

    // ---------------- configuration ----------------
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr     <= 16'd32768;
            r_mw      <= 12'd416;
            r_mh      <= 12'd416;
            r_iw      <= 13'd640;
            r_ih      <= 13'd480;
            r_cls_cnt <= 2'd1;
        end else if (psel && penable && pwrite) begin
            unique case (t_reg_idx'(paddr[4:2]))
                REG_THRESHOLD: r_thr     <= pwdata[15:0];
                REG_MODEL_W:   r_mw      <= pwdata[11:0];
                REG_MODEL_H:   r_mh      <= pwdata[11:0];
                REG_IMAGE_W:   r_iw      <= pwdata[12:0];
                REG_IMAGE_H:   r_ih      <= pwdata[12:0];
                REG_CLASS_CNT: r_cls_cnt <= pwdata[1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (t_reg_idx'(paddr[4:2]))
            REG_THRESHOLD: prdata = 32'(r_thr);
            REG_MODEL_W:   prdata = 32'(r_mw);
            REG_MODEL_H:   prdata = 32'(r_mh);
            REG_IMAGE_W:   prdata = 32'(r_iw);
            REG_IMAGE_H:   prdata = 32'(r_ih);
            REG_CLASS_CNT: prdata = 32'(r_cls_cnt);
            default:       prdata = 32'd0;
        endcase
    end

    // zero model size counts as one
    assign n_mw = (r_mw == 12'd0) ? 12'd1 : r_mw;
    assign n_mh = (r_mh == 12'd0) ? 12'd1 : r_mh;
    assign n_m  = (n_mw < n_mh) ? n_mw : n_mh;

    always_ff @(posedge i_clk) begin
        r_cfg.thr     <= r_thr;
        r_cfg.two_cls <= (32'(r_cls_cnt) >= 2) && (CLASS_MAX >= 2);
        r_cfg.m       <= n_m;
        r_cfg.iw      <= r_iw;
        r_cfg.ax      <= {25'(n_mw) * 25'(r_iw), 1'b0};
        r_cfg.ay      <= {25'(n_mh) * 25'(r_ih), 1'b0};
        r_cfg.bx      <= 25'(n_mw - n_m) * 25'(r_iw);
        r_cfg.by      <= 25'(n_mh - n_m) * 25'(r_ih);
        r_cfg.ch      <= 25'(n_mh) * 25'(r_ih);
        r_cfg.mwm     <= 24'(n_mw) * 24'(n_m);
    end

    // ---------------- pipeline ----------------
    assign en         = !r_out_v || i_m_tready;
    assign o_s_tready = en && i_rst_n;

    assign item.cell_x        = i_s_tdata[5:0];
    assign item.cell_y        = i_s_tdata[11:6];
    assign item.grid_size     = i_s_tdata[18:12];
    assign item.anchor_w      = i_s_tdata[28:19];
    assign item.anchor_h      = i_s_tdata[38:29];
    assign item.logit_x       = i_s_tdata[54:39];
    assign item.logit_y       = i_s_tdata[70:55];
    assign item.logit_w       = i_s_tdata[86:71];
    assign item.logit_h       = i_s_tdata[102:87];
    assign item.logit_obj     = i_s_tdata[118:103];
    assign item.class_logit_a = i_s_tdata[134:119];
    assign item.class_logit_b = i_s_tdata[150:135];

    ybd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_s_tvalid),
        .i_item  (item),
        .i_cfg   (r_cfg),
        .o_valid (f_valid),
        .o_side  (f_side),
        .o_div   (f_div)
    );

    for (genvar d = 0; d < DIV_N; d++) begin : g_div
        ybd_div u_div (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_dvd  (f_div[d].dvd),
            .i_dvs  (f_div[d].dvs),
            .o_quot (quot[d]),
            .o_ovf  (ovf[d])
        );
    end

    // side information travels alongside the dividers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < DIV_LAT; s++) begin
                r_sb_v[s] <= 1'b0;
            end
        end else if (en) begin
            r_sb_v[0] <= f_valid;
            for (int s = 1; s < DIV_LAT; s++) begin
                r_sb_v[s] <= r_sb_v[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sb[0] <= f_side;
            for (int s = 1; s < DIV_LAT; s++) begin
                r_sb[s] <= r_sb[s-1];
            end
        end
    end

    assign sb = r_sb[DIV_LAT-1];

    // centre saturation to [-8192, 8191]
    always_comb begin
        if (!sb.neg_x) begin
            n_cx = (ovf[DIV_CX] || quot[DIV_CX] > 16'd8191) ? 14'h1FFF : quot[DIV_CX][13:0];
        end else begin
            n_cx = (ovf[DIV_CX] || quot[DIV_CX] > 16'd8192) ? 14'h2000
                                                            : 14'(16'd0 - quot[DIV_CX]);
        end
        if (!sb.neg_y) begin
            n_cy = (ovf[DIV_CY] || quot[DIV_CY] > 16'd8191) ? 14'h1FFF : quot[DIV_CY][13:0];
        end else begin
            n_cy = (ovf[DIV_CY] || quot[DIV_CY] > 16'd8192) ? 14'h2000
                                                            : 14'(16'd0 - quot[DIV_CY]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (en) begin
            r_out_v <= r_sb_v[DIV_LAT-1] && sb.pass;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_cx    <= n_cx;
            r_cy    <= n_cy;
            r_bw    <= ovf[DIV_BW] ? 16'hFFFF : quot[DIV_BW];
            r_bh    <= ovf[DIV_BH] ? 16'hFFFF : quot[DIV_BH];
            r_score <= sb.score;
            r_cls   <= sb.cls;
        end
    end

    assign o_m_tvalid = r_out_v;
    assign o_m_tdata  = {4'b0, r_score, r_bh, r_bw, r_cy, r_cx};
    assign o_m_tuser  = r_cls;

endmodule
